/* hdl/i32lp_pkg.sv */
package i32lp_pkg;

    localparam int unsigned CharW  = 8;
    localparam int unsigned ValueW = 32;
    localparam int unsigned CountW = 4;
    localparam int unsigned HexMaxDigits = 8;

    localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CharW-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CharW-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CharW-1:0] CHAR_X_LO  = 8'h78;
    localparam logic [CharW-1:0] CHAR_X_UP  = 8'h58;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic [CharW-1:0] char_code;
        logic             last_char;
    } beat_t;

    typedef struct packed {
        logic  valid;
        beat_t beat;
    } stage_t;

    function automatic logic is_dec(input logic [CharW-1:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_val(input logic [CharW-1:0] c);
        logic [4:0] h;
        h = 5'h10;
        if (c inside {[8'h30:8'h39]})
        begin
            h = {1'b0, c[3:0]};
        end
        else if ((c inside {[8'h61:8'h66]}) || (c inside {[8'h41:8'h46]}))
        begin
            h = {1'b0, c[3:0]} + 5'd9;
        end
        return h;
    endfunction

endpackage

/* hdl/i32lp_fsm.sv */
module i32lp_fsm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  i32lp_pkg::stage_t             stage,
    output logic                          take,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [i32lp_pkg::ValueW-1:0]  value_bits,
    output logic                          status
);
    import i32lp_pkg::*;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGN,
        PH_ZERO,
        PH_PREFIX,
        PH_HEX,
        PH_DEC,
        PH_ERROR
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [ValueW-1:0]   acc_reg, acc_next;
    logic                neg_reg, neg_next;
    logic [CountW-1:0]   count_reg, count_next;
    logic                out_valid_reg;
    logic [ValueW-1:0]   value_reg;
    logic                status_reg;

    logic [CharW-1:0]    c;
    logic [4:0]          h;
    logic [ValueW-1:0]   d;
    logic [ValueW-1:0]   acc_x10;
    logic [ValueW-1:0]   signed_digit;
    logic [ValueW-1:0]   dec_next;

    assign c = stage.beat.char_code;
    assign h = hex_val(c);
    assign d = ValueW'(c[3:0]);
    assign acc_x10 = {acc_reg[ValueW-4:0], 3'b000} + {acc_reg[ValueW-2:0], 1'b0};
    // negative literals accumulate as negative values, same bits mod 2^32
    assign signed_digit = neg_reg ? (ValueW'(0) - d) : d;
    assign dec_next = neg_reg ? (acc_x10 - d) : (acc_x10 + d);

    // a last beat needs the result register free
    assign take = stage.valid && (!stage.beat.last_char || !out_valid_reg || out_ready);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        count_next = count_reg;
        case (phase_reg)
            PH_START:
            begin
                if (c == CHAR_ZERO)
                begin
                    acc_next   = '0;
                    phase_next = PH_ZERO;
                end
                else if (is_dec(c))
                begin
                    acc_next   = d;
                    phase_next = PH_DEC;
                end
                else if (c == CHAR_PLUS)
                begin
                    neg_next   = 1'b0;
                    phase_next = PH_SIGN;
                end
                else if (c == CHAR_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_SIGN;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_SIGN:
            begin
                if (is_dec(c))
                begin
                    acc_next   = signed_digit;
                    phase_next = PH_DEC;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_ZERO:
            begin
                if (is_dec(c))
                begin
                    acc_next   = d;
                    phase_next = PH_DEC;
                end
                else if (c == CHAR_X_LO || c == CHAR_X_UP)
                begin
                    phase_next = PH_PREFIX;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_PREFIX:
            begin
                if (!h[4])
                begin
                    acc_next   = ValueW'(h[3:0]);
                    count_next = CountW'(1);
                    phase_next = PH_HEX;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_HEX:
            begin
                if (!h[4] && count_reg < CountW'(HexMaxDigits))
                begin
                    acc_next   = {acc_reg[ValueW-5:0], h[3:0]};
                    count_next = count_reg + CountW'(1);
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_DEC:
            begin
                if (is_dec(c))
                begin
                    acc_next = dec_next;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            status_reg    <= STATUS_OK;
        end
        else
        begin
            if (out_ready && !(take && stage.beat.last_char))
            begin
                out_valid_reg <= 1'b0;
            end
            if (take)
            begin
                if (stage.beat.last_char)
                begin
                    phase_reg     <= PH_START;
                    acc_reg       <= '0;
                    neg_reg       <= 1'b0;
                    count_reg     <= '0;
                    out_valid_reg <= 1'b1;
                    if (phase_next == PH_ZERO || phase_next == PH_HEX
                        || phase_next == PH_DEC)
                    begin
                        value_reg  <= acc_next;
                        status_reg <= STATUS_OK;
                    end
                    else
                    begin
                        value_reg  <= '0;
                        status_reg <= STATUS_BAD;
                    end
                end
                else
                begin
                    phase_reg <= phase_next;
                    acc_reg   <= acc_next;
                    neg_reg   <= neg_next;
                    count_reg <= count_next;
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign value_bits = value_reg;
    assign status     = status_reg;

`ifndef NO_ASSERTIONS
    a_hex_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEX |-> (count_reg != '0 && count_reg <= CountW'(HexMaxDigits)))
        else $error("hex digit count out of range");

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STATUS_BAD) |-> value_reg == '0)
        else $error("invalid result carries a value");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (take && stage.beat.last_char) |=> (phase_reg == PH_START && count_reg == '0))
        else $error("parser did not restart after last beat");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(take && stage.beat.last_char && out_valid_reg && !out_ready))
        else $error("result overwritten while stalled");
`endif

endmodule

/* hdl/int32_literal_parser_core.sv */
// integer literal parser, one character per beat
// input channel: in_valid/in_ready carry char_code and last_char; last_char
// marks the final character of a literal
// output channel: out_valid/out_ready carry value_bits and status, one beat
// per literal, given on its last character; status 1 means invalid format
// and then value_bits is zero
// accepted forms: 0x/0X with 1 to 8 hex digits, or optional sign and decimal
// digits; decimal wraps modulo 2^32
// path: a last character is held in the input register, then its result is
// loaded into the result register and shown on the output; a stall can come
// between the two while the result register is not yet free
// throughput: one character per cycle unless a last character waits; the
// parse update is a single shallow step from input register to parser state
// stall: while a result waits, the input register still takes characters that
// are not last; a last character waits in the input register until the
// result register frees, and in_ready drops only then
// reset: rst_n clears the input and result registers and returns the parser
// to the start of a literal
module int32_literal_parser_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [i32lp_pkg::CharW-1:0]   char_code,
    input  logic                          last_char,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [i32lp_pkg::ValueW-1:0]  value_bits,
    output logic                          status
);
    import i32lp_pkg::*;

    stage_t stage_reg;
    logic   take;

    assign in_ready = !stage_reg.valid || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                stage_reg.valid          <= 1'b1;
                stage_reg.beat.char_code <= char_code;
                stage_reg.beat.last_char <= last_char;
            end
            else if (take)
            begin
                stage_reg.valid <= 1'b0;
            end
        end
    end

    i32lp_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage_reg),
        .take       (take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value_bits (value_bits),
        .status     (status)
    );

endmodule
